>>> src/terraced_value_noise_height_core_assert.svh
// Assertion macros shared by the height core.
`ifndef TERRACED_VALUE_NOISE_HEIGHT_CORE_ASSERT_SVH
`define TERRACED_VALUE_NOISE_HEIGHT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk, off while rst_n is low
`define TVNH_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvnh assertion failed");
// next-cycle implication
`define TVNH_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvnh assertion failed");
`else
`define TVNH_ASSERT_IMP(name, ante, cons)
`define TVNH_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> src/tvnh_pkg.sv
package tvnh_pkg;

  // octaves and smoothstep fraction width
  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_BITS   = 16;

  // scaled position carries 40 fraction bits (Q16.16 times Q8.24)
  localparam int POS_FRAC = 40;
  localparam int K_W      = $clog2(MAX_OCTAVES + 1);
  localparam int CORNER_W = 16;
  localparam int ACC_W    = CORNER_W + MAX_OCTAVES;

  // reciprocals are floor(2^DIV_N / d); 48 covers ACC_W up to 32
  localparam int DIV_N     = (32 + MAX_OCTAVES > 48) ? 32 + MAX_OCTAVES : 48;
  localparam int DIV_STEPS = DIV_N + 1;
  localparam int R_W       = DIV_N + 1;
  localparam int RLO_W     = (R_W + 1) / 2;
  localparam int RHI_W     = R_W - RLO_W;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int LVL_W     = 16;
  localparam int QN_W      = 33;

  // pipeline depths
  localparam int LANE_LAT = 9;
  localparam int TREE_LV  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int LEAVES   = 1 << TREE_LV;
  localparam int NORM_LAT = 12 + TREE_LV;
  localparam int CORE_LAT = 1 + LANE_LAT + NORM_LAT;

  // lattice hash
  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SEED = 32'd1274126177;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1103515245;
  localparam logic signed [63:0] LATTICE_LIMIT = 64'sd2000000000;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_HEIGHT    = 3'd0,
    REG_RELIEF_GAIN    = 3'd1,
    REG_BASE_FREQ      = 3'd2,
    REG_OCTAVE_COUNT   = 3'd3,
    REG_NOISE_SEED     = 3'd4,
    REG_TERRACE_LEVELS = 3'd5
  } tvnh_reg_t;

  // request to the reciprocal unit
  typedef struct packed {
    logic               go;
    logic               for_levels;
    logic [DIV_D_W-1:0] divisor;
  } tvnh_div_req_t;

  // settings seen by the back end
  typedef struct packed {
    logic signed [31:0] base;
    logic [31:0]        gain;
    logic               flat;
    logic [K_W-1:0]     k;
    logic [LVL_W-1:0]   levels;
    logic [R_W-1:0]     rec_oct;
    logic [R_W-1:0]     rec_lvl;
  } tvnh_cfg_t;

  function automatic logic [K_W-1:0] k_clamp(input logic [3:0] v);
    logic [K_W-1:0] k;
    k = K_W'(v);
    if (32'(v) > MAX_OCTAVES) k = K_W'(MAX_OCTAVES);
    return k;
  endfunction

  // total amplitude 2^k - 1
  function automatic logic [DIV_D_W-1:0] oct_total(input logic [K_W-1:0] k);
    logic [DIV_D_W:0] t;
    t = (DIV_D_W + 1)'(1) << k;
    t = t - (DIV_D_W + 1)'(1);
    return t[DIV_D_W-1:0];
  endfunction

endpackage

>>> src/terraced_value_noise_height_core.sv
// Terrain height from a world position: fractal value noise with optional
// terracing. One position (in_pos_x, in_pos_z) is taken per clock while busy
// is low, and its height appears on out_surface_height with out_valid high for
// one cycle, once it has passed the input register, the octave lanes and the
// normalizer; the receiver cannot stall, so results must be taken as they
// come. All octaves run side by side in lanes, so the rate is one position per
// clock regardless of octave_count. A write to octave_count or terrace_levels
// starts a bit-serial reciprocal; while it runs busy is high and cfg_ready is
// low. Write configuration only while no position is in flight.
`include "terraced_value_noise_height_core_assert.svh"

module terraced_value_noise_height_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_z,
  output logic                            out_valid,
  output logic signed [31:0]              out_surface_height,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tvnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import tvnh_pkg::*;

  // configuration registers
  logic signed [31:0] base_height_r, relief_gain_r;
  logic [31:0]        base_frequency_r, noise_seed_r;
  logic [K_W-1:0]     octave_k_r;
  logic [LVL_W-1:0]   terrace_levels_r;
  logic               cfg_wr, div_busy, in_acc;
  tvnh_div_req_t      div_req;
  logic [R_W-1:0]     rec_oct, rec_lvl;

  assign cfg_ready = !div_busy;
  assign busy      = div_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r    <= '0;
      relief_gain_r    <= '0;
      base_frequency_r <= '0;
      octave_k_r       <= '0;
      noise_seed_r     <= '0;
      terrace_levels_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_BASE_HEIGHT:    base_height_r    <= cfg_data;
        REG_RELIEF_GAIN:    relief_gain_r    <= cfg_data;
        REG_BASE_FREQ:      base_frequency_r <= cfg_data;
        REG_OCTAVE_COUNT:   octave_k_r       <= k_clamp(cfg_data[3:0]);
        REG_NOISE_SEED:     noise_seed_r     <= cfg_data;
        REG_TERRACE_LEVELS: terrace_levels_r <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // reciprocal of 2^k-1 or of the level count
  always_comb begin
    div_req.go         = cfg_wr && ((cfg_index == REG_OCTAVE_COUNT) ||
                                    (cfg_index == REG_TERRACE_LEVELS));
    div_req.for_levels = (cfg_index == REG_TERRACE_LEVELS);
    if (cfg_index == REG_TERRACE_LEVELS) begin
      div_req.divisor = cfg_data[DIV_D_W-1:0];
    end else begin
      div_req.divisor = oct_total(k_clamp(cfg_data[3:0]));
    end
  end

  tvnh_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .busy    (div_busy),
    .rec_oct (rec_oct),
    .rec_lvl (rec_lvl)
  );

  // scaled position, exact with 40 fraction bits
  logic signed [32:0] freq_s;
  logic signed [63:0] px_nxt, pz_nxt, px_r, pz_r;
  assign freq_s = {1'b0, base_frequency_r};
  assign px_nxt = in_pos_x * freq_s;
  assign pz_nxt = in_pos_z * freq_s;
  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    pz_r <= pz_nxt;
  end

  // one lane per octave
  logic [CORNER_W-1:0] noise [MAX_OCTAVES];
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
    tvnh_lane u_lane (
      .clk      (clk),
      .lane_idx (K_W'(g)),
      .seed     (noise_seed_r),
      .px       (px_r),
      .pz       (pz_r),
      .noise    (noise[g])
    );
  end

  // normalize, terrace, scale
  tvnh_cfg_t ncfg;
  always_comb begin
    ncfg.base    = base_height_r;
    ncfg.gain    = relief_gain_r;
    ncfg.flat    = relief_gain_r[31] || (relief_gain_r == '0) ||
                   (base_frequency_r == '0) || (octave_k_r == '0);
    ncfg.k       = octave_k_r;
    ncfg.levels  = terrace_levels_r;
    ncfg.rec_oct = rec_oct;
    ncfg.rec_lvl = rec_lvl;
  end

  logic [31:0] height;
  tvnh_norm u_norm (
    .clk    (clk),
    .cfg    (ncfg),
    .noise  (noise),
    .height (height)
  );

  // valid bits follow the words down the pipe
  logic [CORE_LAT-1:0] valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[CORE_LAT-2:0], in_acc};
    end
  end

  assign out_valid          = valid_r[CORE_LAT-1];
  assign out_surface_height = height;

  `TVNH_ASSERT_IMP(a_out_latency, in_acc, ##CORE_LAT out_valid)
  `TVNH_ASSERT_NXT(a_req_starts_div, div_req.go, busy && !cfg_ready)
  `TVNH_ASSERT_IMP(a_div_length, $rose(busy), ##DIV_STEPS !busy)

endmodule

>>> src/tvnh_lane.sv
module tvnh_lane (
  input  logic                           clk,
  input  logic [tvnh_pkg::K_W-1:0]       lane_idx,
  input  logic [31:0]                    seed,
  input  logic signed [63:0]             px,
  input  logic signed [63:0]             pz,
  output logic [tvnh_pkg::CORNER_W-1:0]  noise
);
  import tvnh_pkg::*;

  localparam int SH_W = 7;
  localparam int FB   = FRAC_BITS;
  localparam int W_W  = FB + 1;
  localparam int P_W  = CORNER_W + W_W;

  function automatic logic [31:0] lattice_cell(input logic signed [63:0] p,
                                               input logic [SH_W-1:0] s);
    logic signed [63:0] ip;
    ip = p >>> s;
    if (ip > LATTICE_LIMIT) ip = LATTICE_LIMIT;
    if (ip < -LATTICE_LIMIT) ip = -LATTICE_LIMIT;
    return ip[31:0];
  endfunction

  function automatic logic [FB-1:0] lattice_frac(input logic signed [63:0] p,
                                                 input logic [SH_W-1:0] s);
    logic [63:0] u;
    u = p;
    u = u >> (s - SH_W'(FB));
    return u[FB-1:0];
  endfunction

  logic [SH_W-1:0] sh;
  assign sh = SH_W'(POS_FRAC) - SH_W'(lane_idx);

  // stage 1: lattice cell and fraction
  logic [31:0]   cx_r, cz_r, seed1_r;
  logic [FB-1:0] fx_r, fz_r;
  always_ff @(posedge clk) begin
    cx_r    <= lattice_cell(px, sh);
    cz_r    <= lattice_cell(pz, sh);
    fx_r    <= lattice_frac(px, sh);
    fz_r    <= lattice_frac(pz, sh);
    seed1_r <= seed + 32'(lane_idx);
  end

  // stage 2: hash partial products, t squared
  logic [31:0]     hx0_r, hx1_r, hz0_r, hz1_r, hs_r;
  logic [2*FB-1:0] tx2_r, tz2_r;
  logic [FB-1:0]   fx2_r, fz2_r;
  always_ff @(posedge clk) begin
    hx0_r <= cx_r * HASH_MUL_X;
    hx1_r <= (cx_r + 32'd1) * HASH_MUL_X;
    hz0_r <= cz_r * HASH_MUL_Z;
    hz1_r <= (cz_r + 32'd1) * HASH_MUL_Z;
    hs_r  <= seed1_r * HASH_MUL_SEED;
    tx2_r <= fx_r * fx_r;
    tz2_r <= fz_r * fz_r;
    fx2_r <= fx_r;
    fz2_r <= fz_r;
  end

  // stage 3: corner hashes, smoothstep product
  logic [31:0]     h_r [4];
  logic [2*FB+1:0] wpx_r, wpz_r;
  logic [FB+1:0]   facx, facz;
  assign facx = (FB + 2)'(3 << FB) - (FB + 2)'({fx2_r, 1'b0});
  assign facz = (FB + 2)'(3 << FB) - (FB + 2)'({fz2_r, 1'b0});
  always_ff @(posedge clk) begin
    h_r[0] <= hx0_r + hz0_r + hs_r;
    h_r[1] <= hx1_r + hz0_r + hs_r;
    h_r[2] <= hx0_r + hz1_r + hs_r;
    h_r[3] <= hx1_r + hz1_r + hs_r;
    wpx_r  <= tx2_r[2*FB-1:FB] * facx;
    wpz_r  <= tz2_r[2*FB-1:FB] * facz;
  end

  // stage 4: hash mix multiply, weights
  logic [31:0]    m_r [4];
  logic [W_W-1:0] wx4_r, wz4_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m_r[i] <= (h_r[i] ^ (h_r[i] >> 13)) * HASH_MUL_MIX;
    end
    wx4_r <= W_W'(wpx_r >> FB);
    wz4_r <= W_W'(wpz_r >> FB);
  end

  // stage 5: corner values, Q0.16
  logic [CORNER_W-1:0] c_r [4];
  logic [31:0]         mf [4];
  logic [W_W-1:0]      wx5_r, wz5_r;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mf[i] = m_r[i] ^ (m_r[i] >> 16);
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      c_r[i] <= mf[i][30:15];
    end
    wx5_r <= wx4_r;
    wz5_r <= wz4_r;
  end

  // stage 6/7: blend along x
  localparam logic [W_W-1:0] ONE = W_W'(1 << FB);
  logic [P_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic [W_W-1:0] wz6_r, wz7_r;
  logic [CORNER_W-1:0] near_r, far_r;
  always_ff @(posedge clk) begin
    pa_r  <= c_r[0] * (ONE - wx5_r);
    pb_r  <= c_r[1] * wx5_r;
    pc_r  <= c_r[2] * (ONE - wx5_r);
    pd_r  <= c_r[3] * wx5_r;
    wz6_r <= wz5_r;
    near_r <= CORNER_W'(((P_W + 1)'(pa_r) + (P_W + 1)'(pb_r)) >> FB);
    far_r  <= CORNER_W'(((P_W + 1)'(pc_r) + (P_W + 1)'(pd_r)) >> FB);
    wz7_r  <= wz6_r;
  end

  // stage 8/9: blend along z
  logic [P_W-1:0]      qa_r, qb_r;
  logic [CORNER_W-1:0] noise_r;
  always_ff @(posedge clk) begin
    qa_r    <= near_r * (ONE - wz7_r);
    qb_r    <= far_r * wz7_r;
    noise_r <= CORNER_W'(((P_W + 1)'(qa_r) + (P_W + 1)'(qb_r)) >> FB);
  end

  assign noise = noise_r;

endmodule

>>> src/tvnh_recip.sv
module tvnh_recip (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tvnh_pkg::tvnh_div_req_t     req,
  output logic                        busy,
  output logic [tvnh_pkg::R_W-1:0]    rec_oct,
  output logic [tvnh_pkg::R_W-1:0]    rec_lvl
);
  import tvnh_pkg::*;

  typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

  dv_state_t            state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W:0]     rem_r, shifted, rem_nxt;
  logic [DIV_D_W-1:0]   dvsr_r;
  logic [R_W-1:0]       quo_r, quo_nxt;
  logic [R_W-1:0]       rec_oct_r, rec_lvl_r;
  logic                 sel_lvl_r;
  logic                 qbit;

  // restoring long division of 2^DIV_N, one quotient bit a cycle
  always_comb begin
    shifted = {rem_r[DIV_D_W-1:0], (cnt_r == '0)};
    qbit    = (shifted >= {1'b0, dvsr_r});
    rem_nxt = qbit ? shifted - {1'b0, dvsr_r} : shifted;
    quo_nxt = {quo_r[R_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      unique case (state_r)
        DV_IDLE: begin
          if (req.go) begin
            state_r   <= DV_RUN;
            cnt_r     <= '0;
            rem_r     <= '0;
            quo_r     <= '0;
            dvsr_r    <= req.divisor;
            sel_lvl_r <= req.for_levels;
          end
        end
        DV_RUN: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + DIV_CNT_W'(1);
          if (cnt_r == DIV_CNT_W'(DIV_N)) begin
            state_r <= DV_IDLE;
            if (sel_lvl_r) begin
              rec_lvl_r <= quo_nxt;
            end else begin
              rec_oct_r <= quo_nxt;
            end
          end
        end
        default: state_r <= DV_IDLE;
      endcase
    end
  end

  assign busy    = (state_r == DV_RUN);
  assign rec_oct = rec_oct_r;
  assign rec_lvl = rec_lvl_r;

endmodule

>>> src/tvnh_norm.sv
module tvnh_norm (
  input  logic                           clk,
  input  tvnh_pkg::tvnh_cfg_t            cfg,
  input  logic [tvnh_pkg::CORNER_W-1:0]  noise [tvnh_pkg::MAX_OCTAVES],
  output logic [31:0]                    height
);
  import tvnh_pkg::*;

  localparam int PROD_W = ACC_W + R_W;
  localparam int DIV_S  = DIV_N - CORNER_W;
  localparam int NUM_W  = ACC_W + CORNER_W;
  localparam int TP_W   = LVL_W + R_W;
  localparam int LQ_W   = 32 + LVL_W;

  logic [DIV_D_W-1:0] total;
  assign total = oct_total(cfg.k);

  // octave weights: leaf o holds n_o << (k-1-o) for active octaves
  logic [ACC_W-1:0] node_r [1:2*LEAVES-1];
  for (genvar o = 0; o < LEAVES; o++) begin : g_leaf
    if (o < MAX_OCTAVES) begin : g_act
      logic [K_W-1:0] amt;
      assign amt = cfg.k - K_W'(1) - K_W'(o);
      always_ff @(posedge clk) begin
        if (cfg.k > K_W'(o)) begin
          node_r[LEAVES+o] <= ACC_W'(noise[o]) << amt;
        end else begin
          node_r[LEAVES+o] <= '0;
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node_r[LEAVES+o] <= '0;
      end
    end
  end

  // registered adder tree
  for (genvar n = 1; n < LEAVES; n++) begin : g_tree
    always_ff @(posedge clk) begin
      node_r[n] <= node_r[2*n] + node_r[2*n+1];
    end
  end

  // divide by 2^k-1: reciprocal product in two halves, then one correction
  logic [ACC_W+RLO_W-1:0]   plo_r;
  logic [ACC_W+RHI_W-1:0]   phi_r;
  logic [ACC_W-1:0]         acc1_r, acc2_r, acc3_r;
  logic [PROD_W-1:0]        prod;
  logic [QN_W-1:0]          q0_r, q0_3_r;
  logic [QN_W+DIV_D_W-1:0]  qt_r;
  logic [NUM_W-1:0]         rem1;
  logic [31:0]              relief_r;

  assign prod = (PROD_W'(phi_r) << RLO_W) + PROD_W'(plo_r);
  assign rem1 = {acc3_r, {CORNER_W{1'b0}}} - NUM_W'(qt_r);

  always_ff @(posedge clk) begin
    plo_r    <= node_r[1] * cfg.rec_oct[RLO_W-1:0];
    phi_r    <= node_r[1] * cfg.rec_oct[R_W-1:RLO_W];
    acc1_r   <= node_r[1];
    q0_r     <= QN_W'(prod >> DIV_S);
    acc2_r   <= acc1_r;
    qt_r     <= q0_r * total;
    q0_3_r   <= q0_r;
    acc3_r   <= acc2_r;
    relief_r <= 32'(q0_3_r + QN_W'(rem1 >= NUM_W'(total)));
  end

  // terraces: q = relief*L >> 32, then q*2^32 / L through the reciprocal
  logic [LQ_W-1:0]        lq_r;
  logic [31:0]            rel1_r, rel2_r, rel3_r, rel4_r, rel5_r;
  logic [LVL_W+RLO_W-1:0] tlo_r;
  logic [LVL_W+RHI_W-1:0] thi_r;
  logic [LVL_W-1:0]       q2_r, q3_r, q4_r;
  logic [TP_W-1:0]        tprod;
  logic [QN_W-1:0]        y0_r, y0_4_r;
  logic [QN_W+LVL_W-1:0]  yl_r;
  logic [LQ_W-1:0]        rem2;

  assign tprod = (TP_W'(thi_r) << RLO_W) + TP_W'(tlo_r);
  assign rem2  = {q4_r, 32'd0} - LQ_W'(yl_r);

  always_ff @(posedge clk) begin
    lq_r   <= relief_r * cfg.levels;
    rel1_r <= relief_r;
    tlo_r  <= lq_r[LQ_W-1:32] * cfg.rec_lvl[RLO_W-1:0];
    thi_r  <= lq_r[LQ_W-1:32] * cfg.rec_lvl[R_W-1:RLO_W];
    q2_r   <= lq_r[LQ_W-1:32];
    rel2_r <= rel1_r;
    y0_r   <= QN_W'(tprod >> (DIV_N - 32));
    q3_r   <= q2_r;
    rel3_r <= rel2_r;
    yl_r   <= y0_r * cfg.levels;
    y0_4_r <= y0_r;
    q4_r   <= q3_r;
    rel4_r <= rel3_r;
    if (cfg.levels == '0) begin
      rel5_r <= rel4_r;
    end else begin
      rel5_r <= 32'(y0_4_r + QN_W'(rem2 >= LQ_W'(cfg.levels)));
    end
  end

  // scale by gain, add base, saturate
  logic [63:0] g_r;
  logic [33:0] sum;
  logic [31:0] height_r;
  assign sum = {{2{cfg.base[31]}}, cfg.base} + {2'b00, g_r[63:32]};

  always_ff @(posedge clk) begin
    g_r <= rel5_r * cfg.gain;
    if (cfg.flat) begin
      height_r <= cfg.base;
    end else if (!sum[33] && (sum[32:31] != 2'b00)) begin
      height_r <= 32'h7FFF_FFFF;
    end else if (sum[33] && (sum[32:31] != 2'b11)) begin
      height_r <= 32'h8000_0000;
    end else begin
      height_r <= sum[31:0];
    end
  end

  assign height = height_r;

endmodule

>>> dv/tb_terraced_value_noise_height_core.sv
`timescale 1ns / 1ps

module tb_terraced_value_noise_height_core;
  import tvnh_pkg::*;

  // indexes beyond the register file, writes are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_EXTRA = 40;

  // expected heights for accepted positions, plus the register shadow
  class height_scoreboard;
    logic signed [31:0] base_h;
    logic signed [31:0] gain;
    logic [31:0]        freq;
    logic [3:0]         octaves;
    logic [31:0]        seed;
    logic [15:0]        levels;
    logic [31:0]        height_q[$];
    int                 errors;

    function new();
      base_h = 0; gain = 0; freq = 0; octaves = 0; seed = 0; levels = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_BASE_HEIGHT:    base_h = d;
        REG_RELIEF_GAIN:    gain = d;
        REG_BASE_FREQ:      freq = d;
        REG_OCTAVE_COUNT:   octaves = d[3:0];
        REG_NOISE_SEED:     seed = d;
        REG_TERRACE_LEVELS: levels = d[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] corner(logic [31:0] lx, logic [31:0] lz, logic [31:0] sd);
      logic [31:0] h;
      h = lx * HASH_MUL_X + lz * HASH_MUL_Z + sd * HASH_MUL_SEED;
      h = (h ^ (h >> 13)) * HASH_MUL_MIX;
      h = h ^ (h >> 16);
      return {48'd0, h[30:15]};
    endfunction

    // floor to a clamped lattice point, top 16 fraction bits as t
    function void split(input logic signed [63:0] p, input int o,
                        output logic [31:0] lat_cell, output logic [63:0] frac);
      logic signed [63:0] ip;
      int s;
      s = 40 - o;
      ip = p >>> s;
      if (ip > 64'sd2000000000) ip = 64'sd2000000000;
      if (ip < -64'sd2000000000) ip = -64'sd2000000000;
      lat_cell = ip[31:0];
      frac = (64'(p) & ((64'd1 << s) - 64'd1)) >> (s - 16);
    endfunction

    function logic [63:0] smooth(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t) >> 16;
      return (t2 * ((64'd3 << 16) - 64'd2 * t)) >> 16;
    endfunction

    function logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
      return (a * ((64'd1 << 16) - w) + b * w) >> 16;
    endfunction

    function logic [31:0] height(logic signed [31:0] x, logic signed [31:0] z);
      logic signed [63:0] xs, zs, fs, px, pz, bs, h;
      logic [63:0] acc, relief, q, total, fx, fz, wx, wz, nr, fr, prod;
      logic [31:0] cx, cz, sd;
      int k;
      k = (octaves > 8) ? 8 : int'(octaves);
      if (gain <= 0 || freq == 0 || k == 0) return base_h;
      xs = x; zs = z; fs = {32'd0, freq}; bs = base_h;
      px = xs * fs;
      pz = zs * fs;
      acc = 0;
      for (int o = 0; o < k; o++) begin
        sd = seed + 32'(o);
        split(px, o, cx, fx);
        split(pz, o, cz, fz);
        wx = smooth(fx);
        wz = smooth(fz);
        nr = blend(corner(cx, cz, sd), corner(cx + 1, cz, sd), wx);
        fr = blend(corner(cx, cz + 1, sd), corner(cx + 1, cz + 1, sd), wx);
        acc += blend(nr, fr, wz) << (k - 1 - o);
      end
      total = (64'd1 << k) - 64'd1;
      relief = (acc << 16) / total;
      if (levels != 0) begin
        q = (relief * {48'd0, levels}) >> 32;
        relief = (q << 32) / {48'd0, levels};
      end
      prod = (relief * {32'd0, gain}) >> 32;
      h = bs + $signed(prod);
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
    endfunction

    function void note_position(logic signed [31:0] x, logic signed [31:0] z);
      height_q = {height_q, height(x, z)};
    endfunction

    function void check_height(logic [31:0] act);
      logic [31:0] exp_h;
      if (height_q.size() == 0) begin
        $display("%0t: unexpected height word %h", $time, act);
        errors++;
      end else begin
        exp_h = height_q.pop_front();
        if (exp_h !== act) begin
          $display("%0t: height mismatch expected %h actual %h", $time, exp_h, act);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  logic signed [31:0] in_pos_x, in_pos_z, out_surface_height;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  height_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_gaps = 0;

  terraced_value_noise_height_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_surface_height(out_surface_height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_height(out_surface_height);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one position word, held until busy is low at an edge
  task send_position(logic signed [31:0] x, logic signed [31:0] z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1; in_pos_x <= x; in_pos_z <= z;
    do @(posedge clk); while (busy);
    sb.note_position(x, z);
    @(negedge clk);
  endtask

  // pause until nothing is in flight
  task drain();
    start <= 0;
    @(negedge clk);
    while (sb.height_q.size() != 0) @(negedge clk);
    repeat (DRAIN_EXTRA) @(negedge clk);
  endtask

  // valid stays high on return; the caller drops it after its last word
  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  task apply_settings(logic [31:0] b, logic [31:0] g, logic [31:0] f,
                      logic [3:0] o, logic [31:0] s, logic [15:0] l);
    drain();
    write_cfg(REG_BASE_HEIGHT, b);
    write_cfg(REG_RELIEF_GAIN, g);
    write_cfg(REG_BASE_FREQ, f);
    write_cfg(REG_OCTAVE_COUNT, {28'd0, o});
    write_cfg(REG_NOISE_SEED, s);
    write_cfg(REG_TERRACE_LEVELS, {16'd0, l});
    cfg_valid <= 0;
  endtask

  function logic [31:0] rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 8) return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  function logic [31:0] rand_edge32(logic [31:0] lo_v, logic [31:0] hi_v);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo_v;
    if (r == 1) return hi_v;
    return $urandom();
  endfunction

  initial begin
    logic [31:0] g, f;
    logic [15:0] l;
    start = 0; in_pos_x = 0; in_pos_z = 0;
    cfg_valid = 0; cfg_index = REG_BASE_HEIGHT; cfg_data = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset settings: flat floor at zero
    send_position(32'h7FFF_FFFF, 32'h8000_0000);
    send_position(32'h0001_8000, 32'hFFFF_0000);

    // full relief, seed wraps with the octave number
    apply_settings(32'h0, 32'h7FFF_FFFF, 32'h0100_0000, 4'd8, 32'hFFFF_FFFF, 16'd0);
    send_position(32'h0, 32'h0);
    send_position(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_position(32'h0000_8000, 32'h0001_8000);
    send_position(32'h7FFF_FFFF, 32'h8000_0000);
    // far lattice cells, octave count above the maximum
    apply_settings(32'h7FFF_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd15, 32'h0, 16'd65535);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_position(32'h8000_0000, 32'h8000_0000);
    send_position(32'h1234_5678, 32'h8765_4321);
    // single terrace level, floor at minimum
    apply_settings(32'h8000_0000, 32'h0001_0000, 32'h0080_0000, 4'd1, 32'h1, 16'd1);
    send_position(32'h0003_4000, 32'hFFF0_C000);
    send_position(32'h7FFF_FFFF, 32'h0);
    // negative gain, then zero frequency: flat floor
    apply_settings(32'h0005_0000, 32'h8000_0000, 32'h0100_0000, 4'd4, 32'h77, 16'd3);
    send_position(32'h0002_0000, 32'h0003_0000);
    apply_settings(32'hFFFF_0000, 32'h0001_0000, 32'h0, 4'd4, 32'h77, 16'd3);
    send_position(32'h0002_0000, 32'h0003_0000);
    // writes to unknown indexes leave the settings alone
    drain();
    write_cfg(REG_SPARE_6, $urandom());
    write_cfg(REG_SPARE_7, $urandom());
    cfg_valid <= 0;
    send_position(32'h0002_0000, 32'h0003_0000);

    // random phases, each ending in a full drain
    for (int ph = 0; ph < 14; ph++) begin
      g = rand_edge32(32'h0, 32'h7FFF_FFFF);
      if ($urandom_range(0, 9) < 7) g[31] = 0;
      f = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h0400_0000) :
          rand_edge32(32'h0, 32'hFFFF_FFFF);
      l = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom());
      if (ph == 5) l = 16'hFFFF;
      apply_settings(rand_edge32(32'h8000_0000, 32'h7FFF_FFFF), g, f,
                     4'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) :
                                                     $urandom_range(0, 15)),
                     $urandom(), l);
      no_gaps = (ph % 4 == 1);
      for (int i = 0; i < 115; i++) send_position(rand_pos(), rand_pos());
    end
    no_gaps = 0;

    drain();
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
